// ===== rtl/first_fit_block_allocator_top_assert.svh =====
// Assertion macros for the first-fit block allocator checkers.
// Depends on nothing; included by the checker file.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FFBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define FFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ffba_pkg.sv =====
// Shared constants, codes and types of the first-fit block allocator.
// No dependencies; imported by every allocator module.
package ffba_pkg;

    // Map geometry
    localparam int NUM_BLOCKS = 4096;
    localparam int WORD_W     = 32;
    localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W    = $clog2(MAP_WORDS);
    localparam int OFF_W      = $clog2(WORD_W);
    localparam int BIDX_W     = 12;
    localparam int CNT_W      = 13;
    localparam int STAT_W     = 2;

    localparam logic [WORD_W-1:0] WORD_ONES = '1;
    localparam logic [CNT_W-1:0]  MAX_TOTAL = CNT_W'(NUM_BLOCKS);

    // Request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_CNT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_ROOM   = 2'd2;
    localparam logic [STAT_W-1:0] ST_OUT_RANGE = 2'd3;

    // Register index (word address bit of paddr)
    localparam logic REG_TOTAL_BLOCKS = 1'b0;

    // Request handed from the top to the core
    typedef struct packed {
        logic              func;
        logic [CNT_W-1:0]  count;
        logic [BIDX_W-1:0] index;
    } t_req;

    // Result handed from the core to the top
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BIDX_W-1:0] start;
    } t_result;

    // Outcome of evaluating one map word
    typedef struct packed {
        logic             found;     // run of count free blocks ends in this word
        logic             from_run;  // the run started at the tracked run start
        logic [OFF_W-1:0] off;       // start offset of a run found inside the word
        logic             any_used;  // word holds a used (or masked) block
        logic [OFF_W-1:0] hi_used;   // highest used position in the word
    } t_eval;

endpackage

// ===== rtl/ffba_word_eval.sv =====
// Word evaluator: first-fit run search over one 32-bit map word.
// Depends on ffba_pkg; used by ffba_core once per scanned word.
module ffba_word_eval
    import ffba_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    input  logic [OFF_W-1:0]  i_lo_off,
    input  logic [OFF_W-1:0]  i_hi_off,
    input  logic [CNT_W-1:0]  i_run,
    input  logic [CNT_W-1:0]  i_count,
    output t_eval             o_res
);

    logic [WORD_W-1:0] lo_valid;
    logic [WORD_W-1:0] hi_valid;
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] a;
    logic              a_open;
    logic [WORD_W-1:0] g;
    logic [WORD_W-1:0] p [0:OFF_W];
    logic [OFF_W:0]    pre;
    logic [OFF_W-1:0]  hz;
    logic [OFF_W-1:0]  gl;
    logic [CNT_W:0]    run_sum;
    logic              found_a;

    // Free mask: blocks below the hint or at/after the total count as used
    always_comb begin
        lo_valid = WORD_ONES << i_lo_off;
        hi_valid = WORD_ONES >> (OFF_W'(WORD_W - 1) - i_hi_off);
        m        = ~i_word & lo_valid & hi_valid;
    end

    // p[b]: positions ending a free run of 2^b; a: positions ending a free run of count bits
    always_comb begin
        p[0] = m;
        for (int b = 1; b <= OFF_W; b++) begin
            p[b] = p[b-1] & (p[b-1] << (1 << (b - 1)));
        end
        a      = WORD_ONES;
        a_open = 1'b1;
        for (int b = 0; b <= OFF_W; b++) begin
            if (i_count[b]) begin
                // only the first piece of the run may begin at bit 0
                a      = a_open ? p[b] : (p[b] & (a << (1 << b)));
                a_open = 1'b0;
            end
        end
        g = (i_count <= CNT_W'(WORD_W)) ? a : '0;
    end

    // Priority encoders: trailing free bits, highest used bit, first run end
    always_comb begin
        pre = (OFF_W+1)'(WORD_W);
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!m[i]) begin
                pre = (OFF_W+1)'(i);
            end
        end
        hz = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (!m[i]) begin
                hz = OFF_W'(i);
            end
        end
        gl = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (g[i]) begin
                gl = OFF_W'(i);
            end
        end
    end

    // A run carried in from earlier words wins over one inside the word
    always_comb begin
        run_sum        = {1'b0, i_run} + (CNT_W+1)'(pre);
        found_a        = run_sum >= {1'b0, i_count};
        o_res.found    = found_a | (|g);
        o_res.from_run = found_a;
        o_res.off      = gl - i_count[OFF_W-1:0] + OFF_W'(1);
        o_res.any_used = ~&m;
        o_res.hi_used  = hz;
    end

endmodule

// ===== rtl/ffba_core.sv =====
// Allocator core: used-bit map RAM, search hint and the scan/mark sequencer.
// Depends on ffba_pkg and ffba_word_eval.
module ffba_core
    import ffba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_total,
    input  logic             i_start,
    input  t_req             i_req,
    output logic             o_idle,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res
);

    // Sequencer states
    localparam logic [2:0] S_CLR     = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_SCAN_RD = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_MK_RD   = 3'd4;
    localparam logic [2:0] S_MK_WR   = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [WADDR_W-1:0] r_clr, n_clr;
    logic [CNT_W-1:0]   r_hint, n_hint;
    logic               r_func, n_func;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [WADDR_W-1:0] r_w, n_w;
    logic [CNT_W-1:0]   r_run, n_run;
    logic [CNT_W-1:0]   r_rstart, n_rstart;
    logic               r_first, n_first;
    logic [BIDX_W-1:0]  r_start, n_start;
    logic [CNT_W-1:0]   r_end, n_end;
    logic [STAT_W-1:0]  r_status, n_status;

    // Map RAM
    logic [WORD_W-1:0]  mem [0:MAP_WORDS-1];
    logic [WORD_W-1:0]  r_rdata;
    logic               we;
    logic [WADDR_W-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
    logic [WADDR_W-1:0] raddr;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    // Scan bounds
    logic [CNT_W-1:0]   total_m1;
    logic [WADDR_W-1:0] last_word;
    logic [CNT_W-1:0]   end_m1;
    logic [CNT_W:0]     free_end;

    assign total_m1  = i_total - CNT_W'(1);
    assign last_word = total_m1[BIDX_W-1:OFF_W];
    assign end_m1    = r_end - CNT_W'(1);
    assign free_end  = (CNT_W+1)'(i_req.index) + (CNT_W+1)'(i_req.count);

    // Shared word evaluator
    t_eval            ev;
    logic [OFF_W-1:0] ev_lo;
    logic [OFF_W-1:0] ev_hi;

    assign ev_lo = r_first ? r_hint[OFF_W-1:0] : '0;
    assign ev_hi = (r_w == last_word) ? total_m1[OFF_W-1:0] : OFF_W'(WORD_W - 1);

    ffba_word_eval u_eval (
        .i_word   (r_rdata),
        .i_lo_off (ev_lo),
        .i_hi_off (ev_hi),
        .i_run    (r_run),
        .i_count  (r_count),
        .o_res    (ev)
    );

    // Bit mask of the blocks in word r_w that the current range covers
    logic [OFF_W-1:0]  mk_lo;
    logic [OFF_W-1:0]  mk_hi;
    logic [WORD_W-1:0] mk_mask;
    logic [BIDX_W-1:0] found_start;

    always_comb begin
        mk_lo   = (r_w == r_start[BIDX_W-1:OFF_W]) ? r_start[OFF_W-1:0] : '0;
        mk_hi   = (r_w == end_m1[BIDX_W-1:OFF_W]) ? end_m1[OFF_W-1:0]
                                                 : OFF_W'(WORD_W - 1);
        mk_mask = (WORD_ONES << mk_lo) & (WORD_ONES >> (OFF_W'(WORD_W - 1) - mk_hi));
        found_start = ev.from_run ? r_rstart[BIDX_W-1:0] : {r_w, ev.off};
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_hint   = r_hint;
        n_func   = r_func;
        n_count  = r_count;
        n_w      = r_w;
        n_run    = r_run;
        n_rstart = r_rstart;
        n_first  = r_first;
        n_start  = r_start;
        n_end    = r_end;
        n_status = r_status;
        we       = 1'b0;
        waddr    = r_w;
        wdata    = r_rdata;
        raddr    = r_w;
        case (r_state)
            S_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                n_clr = r_clr + WADDR_W'(1);
                if (r_clr == WADDR_W'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_func   = i_req.func;
                    n_count  = i_req.count;
                    n_status = ST_OK;
                    if (i_req.count == '0) begin
                        n_status = ST_ZERO_CNT;
                        n_state  = S_DONE;
                    end else if (i_req.func == FUNC_ALLOC) begin
                        if (r_hint >= i_total) begin
                            n_status = ST_NO_ROOM;
                            n_state  = S_DONE;
                        end else begin
                            n_w      = r_hint[BIDX_W-1:OFF_W];
                            n_first  = 1'b1;
                            n_run    = '0;
                            n_rstart = r_hint;
                            n_state  = S_SCAN_RD;
                        end
                    end else begin
                        if (free_end > (CNT_W+1)'(i_total)) begin
                            n_status = ST_OUT_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_start = i_req.index;
                            n_end   = free_end[CNT_W-1:0];
                            if (CNT_W'(i_req.index) < r_hint) begin
                                n_hint = CNT_W'(i_req.index);
                            end
                            n_state = S_MK_RD;
                        end
                    end
                end
            end
            S_SCAN_RD: begin
                raddr   = r_w;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // evaluate word r_w while fetching the next one
                raddr = r_w + WADDR_W'(1);
                if (ev.found) begin
                    n_start = found_start;
                    n_end   = CNT_W'(found_start) + r_count;
                    if (r_count == CNT_W'(1)) begin
                        n_hint = CNT_W'(found_start) + CNT_W'(1);
                    end
                    n_state = S_MK_RD;
                end else if (r_w == last_word) begin
                    n_status = ST_NO_ROOM;
                    n_state  = S_DONE;
                end else begin
                    n_w     = r_w + WADDR_W'(1);
                    n_first = 1'b0;
                    if (ev.any_used) begin
                        n_run    = CNT_W'(OFF_W'(WORD_W - 1) - ev.hi_used);
                        n_rstart = CNT_W'({r_w, ev.hi_used}) + CNT_W'(1);
                    end else begin
                        n_run = r_run + CNT_W'(WORD_W);
                    end
                end
            end
            S_MK_RD: begin
                raddr   = r_start[BIDX_W-1:OFF_W];
                n_w     = r_start[BIDX_W-1:OFF_W];
                n_state = S_MK_WR;
            end
            S_MK_WR: begin
                // read-modify-write word r_w, fetch the next word
                we    = 1'b1;
                waddr = r_w;
                wdata = (r_func == FUNC_ALLOC) ? (r_rdata | mk_mask) : (r_rdata & ~mk_mask);
                raddr = r_w + WADDR_W'(1);
                if (r_w == end_m1[BIDX_W-1:OFF_W]) begin
                    n_state = S_DONE;
                end else begin
                    n_w = r_w + WADDR_W'(1);
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_hint  <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_hint  <= n_hint;
        end
    end

    // Working registers of the current transaction
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_count  <= n_count;
        r_w      <= n_w;
        r_run    <= n_run;
        r_rstart <= n_rstart;
        r_first  <= n_first;
        r_start  <= n_start;
        r_end    <= n_end;
        r_status <= n_status;
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.start  = (r_status == ST_OK && r_func == FUNC_ALLOC) ? r_start : '0;

endmodule

// ===== rtl/first_fit_block_allocator_top.sv =====
// First-fit block allocator: keeps one used bit per block (4096 blocks, held as
// 128 words of 32 bits in a single RAM) and a search hint below which every block
// is used. An allocate transaction scans the map from the hint for the first run of
// block_count free blocks, marks them used and returns the start block; a free
// transaction clears block_count blocks from block_index and lowers the hint.
// The map RAM delivers one word per cycle, and the scan and the marking both walk
// it at that pace. An allocate scans the words from the hint word up to the word
// where the run ends (at most 128 words) and then rewrites the words the run
// covers; an allocate that finds no room only scans; a free only rewrites the
// words its range covers; a zero count, an out-of-range free or an allocate with
// the hint at or past the total goes straight to the result. One transaction is
// in work at a time. After reset a clearing pass zeroes the map, during which no
// transaction is accepted (the APB port works throughout). total_blocks must be
// written by the user only while the block is idle; the block does not enforce it.
// Depends on ffba_pkg and ffba_core.
module first_fit_block_allocator_top
    import ffba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [CNT_W-1:0]   i_block_count,
    input  logic [BIDX_W-1:0]  i_block_index,
    // Result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [STAT_W-1:0]  o_status,
    output logic [BIDX_W-1:0]  o_start_block
);

    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] total_eff;
    logic             core_idle;
    logic             res_valid;
    logic             res_ready;
    t_req             req;
    t_result          res;
    logic             r_out_valid;
    t_result          r_out;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= MAX_TOTAL;
        end else if (psel && penable && pwrite && paddr[2] == REG_TOTAL_BLOCKS) begin
            r_total <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata    = (paddr[2] == REG_TOTAL_BLOCKS) ? 32'(r_total) : '0;
    assign total_eff = (r_total > MAX_TOTAL) ? MAX_TOTAL : r_total;

    // Core
    assign o_in_ready = core_idle;
    assign req.func   = i_func;
    assign req.count  = i_block_count;
    assign req.index  = i_block_index;

    ffba_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_total     (total_eff),
        .i_start     (i_in_valid && core_idle),
        .i_req       (req),
        .o_idle      (core_idle),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Output register
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_start_block = r_out.start;

endmodule

// ===== rtl/ffba_checker.sv =====
// Port-level checker for the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_top_assert.svh.
`include "first_fit_block_allocator_top_assert.svh"

module ffba_checker
    import ffba_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [STAT_W-1:0] o_status,
    input logic [BIDX_W-1:0] o_start_block
);

    // A stalled result transaction holds its payload
    `FFBA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_start_block), "result changed while stalled")

    // Only a successful allocate reports a nonzero start block
    `FFBA_ASSERT_NOW(a_start_zero, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_start_block == '0, "nonzero start block on failed request")

    // An accepted request keeps the block busy for at least the next cycle
    `FFBA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready right after accepting a request")

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_start_block (o_start_block)
);

// ===== bench/ffba_alloc_check.sv =====
`timescale 1ns / 100ps
// Result checker for the first-fit block allocator: predicts each reply from its own
// copy of the block map and hint, and compares every reply in order.
// Depends on ffba_pkg; instantiated next to the block by the bench top.
module ffba_alloc_check
    import ffba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // APB writes, watched to track total_blocks
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    // Request channel
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  logic               i_func,
    input  logic [CNT_W-1:0]   i_block_count,
    input  logic [BIDX_W-1:0]  i_block_index,
    // Result channel
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic [STAT_W-1:0]  o_status,
    input  logic [BIDX_W-1:0]  o_start_block,
    // To the bench top
    output int                 o_fail_count,
    output int                 o_pending
);

    // Predicted state of the allocator
    logic [NUM_BLOCKS-1:0] block_taken;
    int                    scan_hint;
    logic [CNT_W-1:0]      total_cfg;

    // Replies owed by the block, oldest first
    t_result replies_due[$];

    // Serve one request on the predicted map; returns the reply it earns
    function automatic t_result grant_or_release(logic func, int count, int index);
        t_result rep;
        int      limit;
        int      b;
        int      run;
        int      run_start;
        bit      found;
        rep.status = ST_OK;
        rep.start  = '0;
        limit = (int'(total_cfg) > NUM_BLOCKS) ? NUM_BLOCKS : int'(total_cfg);
        if (count == 0) begin
            rep.status = ST_ZERO_CNT;
        end else if (func == FUNC_ALLOC) begin
            // first fit, scanning upward from the hint
            run       = 0;
            run_start = scan_hint;
            found     = 1'b0;
            b         = scan_hint;
            while (!found && b < limit) begin
                if (block_taken[b]) begin
                    run       = 0;
                    run_start = b + 1;
                end else begin
                    run++;
                    found = (run >= count);
                end
                b++;
            end
            if (!found) begin
                rep.status = ST_NO_ROOM;
            end else begin
                for (b = run_start; b < run_start + count; b++)
                    block_taken[b] = 1'b1;
                if (count == 1)
                    scan_hint = run_start + 1;
                rep.start = BIDX_W'(run_start);
            end
        end else if (index + count > limit) begin
            rep.status = ST_OUT_RANGE;
        end else begin
            for (b = index; b < index + count; b++)
                block_taken[b] = 1'b0;
            if (index < scan_hint)
                scan_hint = index;
        end
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            block_taken = '0;
            scan_hint   = 0;
            total_cfg   = MAX_TOTAL;
            replies_due.delete();
        end else begin
            // register write
            if (psel && penable && pwrite && pready && paddr[2] == REG_TOTAL_BLOCKS
                    && paddr[1:0] == 2'b00)
                total_cfg = pwdata[CNT_W-1:0];

            // reply transaction: compare against the oldest prediction
            if (o_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected reply: status %0d start_block %0d",
                           o_status, o_start_block);
                    o_fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (o_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, o_status);
                        o_fail_count++;
                    end
                    if (o_start_block !== want.start) begin
                        $error("start_block mismatch: expected %0d, actual %0d",
                               want.start, o_start_block);
                        o_fail_count++;
                    end
                end
            end

            // request transaction: predict its reply
            if (i_in_valid && o_in_ready)
                replies_due.push_back(grant_or_release(i_func, int'(i_block_count),
                                                       int'(i_block_index)));
        end
        o_pending = replies_due.size();
    end

endmodule

// ===== bench/first_fit_block_allocator_top_tb.sv =====
`timescale 1ns / 100ps
// Bench top for the first-fit block allocator: clock, reset, APB setup, request
// stimulus and reply back-pressure; verdict from ffba_alloc_check.
// Depends on ffba_pkg, first_fit_block_allocator_top and ffba_alloc_check.
module first_fit_block_allocator_top_tb;
    import ffba_pkg::*;

    localparam int   HOLD_CYCLES  = 500;   // long reply stall to back the block up
    localparam int   QUIET_LIMIT  = 6000;  // cycles without any transaction
    localparam int   BIDX_MAX     = 4095;
    localparam int   CNT_MAX      = 8191;
    localparam logic REG_SPARE    = 1'b1;  // unmapped register slot

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_func;
    logic [CNT_W-1:0]   i_block_count;
    logic [BIDX_W-1:0]  i_block_index;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [STAT_W-1:0]  o_status;
    logic [BIDX_W-1:0]  o_start_block;

    int fail_count;
    int pending;
    int cur_limit;     // managed block count as the bench last set it
    int quiet_cycles;
    bit steady;        // no idling on either side
    bit hold_req;      // ask the receiver for a long stall

    first_fit_block_allocator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_block_count (i_block_count),
        .i_block_index (i_block_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_start_block (o_start_block)
    );

    ffba_alloc_check u_alloc_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_block_count (i_block_count),
        .i_block_index (i_block_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_start_block (o_start_block),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: too long without any transaction ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Reply side: random stalls, one long hold on request
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (hold_req) begin
                hold_req    = 1'b0;
                stall_left  = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(99) >= 29);
            end
        end
    end

    // Offer one request, with random gaps ahead of it, and wait for its transaction
    task automatic send_request(input logic func, input int count, input int index);
        while (!steady && $urandom_range(99) < 29) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_block_count <= CNT_W'(count);
        i_block_index <= BIDX_W'(index);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every reply is in
    task automatic drain_replies();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // APB write while the block is idle
    task automatic write_reg(input logic idx, input int value);
        drain_replies();
        repeat (8) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TOTAL_BLOCKS)
            cur_limit = ((value & CNT_MAX) > NUM_BLOCKS) ? NUM_BLOCKS : (value & CNT_MAX);
    endtask

    // Random request: mostly sensible allocs and in-range frees, some noise
    task automatic pick_request(output logic func, output int count, output int index);
        int roll;
        int span;
        roll  = $urandom_range(99);
        func  = FUNC_FREE;
        count = 0;
        index = $urandom_range(BIDX_MAX);
        if (roll < 8) begin
            func  = 1'($urandom_range(1));
            count = $urandom_range(CNT_MAX);
        end else if (roll < 10) begin
            func = 1'($urandom_range(1));          // zero count
        end else if (roll < 52) begin
            func = FUNC_ALLOC;
            span = $urandom_range(99);
            if (span < 70)
                count = $urandom_range(4, 1);
            else if (span < 95)
                count = $urandom_range(40, 5);
            else
                count = $urandom_range(600, 41);
        end else if (cur_limit == 0) begin
            count = $urandom_range(8, 1);
        end else if (roll < 96) begin
            index = $urandom_range(cur_limit - 1);
            span  = cur_limit - index;
            if (span > 24)
                span = 24;
            count = $urandom_range(span, 1);
        end else begin
            index = 0;                              // release the whole managed range
            count = cur_limit;
        end
    endtask

    // Random phase with an optional long reply stall and a no-idle stretch
    task automatic run_random(input int n_items, input int hold_at,
                              input int calm_from, input int calm_to);
        logic func;
        int   count;
        int   index;
        for (int n = 0; n < n_items; n++) begin
            steady = (n >= calm_from && n < calm_to);
            if (n == hold_at)
                hold_req = 1'b1;
            pick_request(func, count, index);
            send_request(func, count, index);
        end
        steady = 1'b0;
    endtask

    // Main sequence
    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_func        = FUNC_ALLOC;
        i_block_count = '0;
        i_block_index = '0;
        quiet_cycles  = 0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        cur_limit     = NUM_BLOCKS;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero counts, singles moving the hint, refilling a freed hole
        send_request(FUNC_ALLOC, 0, 0);
        send_request(FUNC_FREE, 0, BIDX_MAX);
        send_request(FUNC_ALLOC, 1, 0);
        send_request(FUNC_ALLOC, 1, BIDX_MAX);
        send_request(FUNC_ALLOC, 5, 0);
        send_request(FUNC_FREE, 1, 1);
        send_request(FUNC_ALLOC, 1, 0);
        // freeing blocks that are already free
        send_request(FUNC_FREE, 10, 100);
        // out of range free, then whole map free and full allocate
        send_request(FUNC_FREE, 2, BIDX_MAX);
        send_request(FUNC_FREE, NUM_BLOCKS, 0);
        send_request(FUNC_ALLOC, NUM_BLOCKS, 0);
        send_request(FUNC_ALLOC, 1, 0);
        send_request(FUNC_FREE, 1, BIDX_MAX);
        send_request(FUNC_ALLOC, 1, 0);
        // largest count field in both kinds, and a count just above the map
        send_request(FUNC_ALLOC, CNT_MAX, 0);
        send_request(FUNC_FREE, CNT_MAX, 0);
        send_request(FUNC_FREE, NUM_BLOCKS, 0);
        send_request(FUNC_ALLOC, NUM_BLOCKS + 1, 0);

        // No managed blocks at all
        write_reg(REG_TOTAL_BLOCKS, 0);
        send_request(FUNC_ALLOC, 1, 0);
        send_request(FUNC_FREE, 1, 0);

        // Oversized total saturates to the map size; spare slot is ignored
        write_reg(REG_TOTAL_BLOCKS, CNT_MAX);
        write_reg(REG_SPARE, 3);
        send_request(FUNC_ALLOC, NUM_BLOCKS, 0);
        send_request(FUNC_FREE, NUM_BLOCKS, 0);

        // Single managed block
        write_reg(REG_TOTAL_BLOCKS, 1);
        send_request(FUNC_ALLOC, 1, 0);
        send_request(FUNC_ALLOC, 1, 0);
        send_request(FUNC_FREE, 2, 0);
        send_request(FUNC_FREE, 1, 0);

        // Hint left above a lowered total
        write_reg(REG_TOTAL_BLOCKS, NUM_BLOCKS);
        send_request(FUNC_ALLOC, 1, 0);
        send_request(FUNC_ALLOC, 1, 0);
        send_request(FUNC_ALLOC, 1, 0);
        write_reg(REG_TOTAL_BLOCKS, 2);
        send_request(FUNC_ALLOC, 1, 0);
        send_request(FUNC_FREE, 2, 0);

        // Random phases over several map sizes
        write_reg(REG_TOTAL_BLOCKS, NUM_BLOCKS);
        run_random(250, 40, 100, 180);
        write_reg(REG_TOTAL_BLOCKS, 64);
        run_random(150, -1, -1, -1);
        write_reg(REG_TOTAL_BLOCKS, $urandom_range(NUM_BLOCKS, 1));
        run_random(150, -1, -1, -1);

        // Wait out the last replies, then watch for strays
        drain_replies();
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ffba_pkg.sv
rtl/ffba_word_eval.sv
rtl/ffba_core.sv
rtl/first_fit_block_allocator_top.sv
rtl/ffba_checker.sv
bench/ffba_alloc_check.sv
bench/first_fit_block_allocator_top_tb.sv
